FILE: rtl/core/ssvd_pkg.sv
`default_nettype none

package ssvd_pkg;

    // Four display digits of one value, digit 0 (leftmost) in the low byte
    typedef logic [3:0][7:0] t_digits;

    // Segment patterns: bit7 DP, bits6..0 G..A
    localparam logic [7:0] SEG_OVER  = 8'b0101_1100;
    localparam logic [7:0] SEG_MINUS = 8'b0100_0000;
    localparam logic [7:0] SEG_DOT   = 8'b1000_0000;
    localparam logic [7:0] SEG_NINE  = 8'b0110_1111;

    // Driver commands
    localparam logic [7:0] CMD_DATA          = 8'h40;
    localparam logic [7:0] CMD_ADDR          = 8'b1100_0000;
    localparam logic [7:0] CMD_SINGLE_BRIGHT = 8'b1000_1100;
    localparam logic [7:0] CMD_BRIGHT_OFF    = 8'b1000_0000;
    localparam logic [7:0] CMD_BRIGHT_BASE   = 8'b1000_0111;
    localparam logic [3:0] BRIGHT_MAX        = 4'd8;

    // Register indexes on the config port
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_BRIGHT = 1'b1;

    // Byte positions in the output sequence
    localparam logic [3:0] IDX_DATA     = 4'd0;
    localparam logic [3:0] IDX_ADDR     = 4'd1;
    localparam logic [3:0] IDX_DIG0     = 4'd2;
    localparam logic [3:0] IDX_LAST_ONE = 4'd6;
    localparam logic [3:0] IDX_LAST_TWO = 4'd10;

    // Reciprocals for divide by constant: floor(x*M >> S)
    localparam logic [17:0] RECIP10_S21   = 18'd209716;
    localparam logic [12:0] RECIP10_S16   = 13'd6554;
    localparam logic [13:0] RECIP100_S20  = 14'd10486;
    localparam logic [14:0] RECIP1000_S24 = 15'd16778;

    // Range limits
    localparam logic signed [17:0] POS_RAW_LIMIT = 18'sd100000;
    localparam logic signed [17:0] NEG_RAW_LIMIT = -18'sd10000;
    localparam logic [13:0] POS_TEN_LIMIT = 14'd10000;
    localparam logic [13:0] NEG_TEN_LIMIT = 14'd1000;

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h27;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Brightness command: 0 is off, 1..8 map to 0x88..0x8F, above 8 saturates
    function automatic logic [7:0] bright_cmd(input logic [3:0] level);
        logic [3:0] lv;
        logic [7:0] c;
        lv = (level > BRIGHT_MAX) ? BRIGHT_MAX : level;
        if (lv == 4'd0) begin
            c = CMD_BRIGHT_OFF;
        end else begin
            c = CMD_BRIGHT_BASE + {4'd0, lv};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/seven_segment_value_display_frame.sv
// Seven-segment value display frame encoder.
// Input stream: each item carries two signed values in hundredths. Each value
// is rounded half away from zero to tenths and turned into four segment bytes.
// Output stream: one driver byte per transfer, tuser = {frame_end, frame_start},
// tlast marks the final byte of an input item. Per input item the block sends
// 0x40, then 0xC0 with 4 or 8 digit bytes, then the brightness command:
// 7 bytes in single-value mode, 11 bytes in two-value mode.
// The first byte passes the first lane stage, which loads with the item,
// then two more lane stages, the digit holding register and the output
// register. Throughput: one output byte per cycle while the receiver does
// not stall. Three items can sit in the lanes while a previous one is still
// being sent.
// When the receiver stalls, the output register holds its byte and the lanes
// stop once their last stage holds an item; s_axis_tready then drops.
// Reset (synchronous, active low) empties the pipeline and sets two-value mode
// with brightness level 5. Configuration goes through the APB port at byte
// addresses 0 (mode) and 4 (brightness); write only while the block is idle.
`default_nettype none

module seven_segment_value_display_frame
    import ssvd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [17:0] first_value, [35:18] second_value
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]       m_axis_tuser,   // [0] frame_start, [1] frame_end
    output logic             m_axis_tlast,
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       r_mode;
    logic [3:0] r_bright;
    logic       w_en;
    t_digits    w_dig_a;
    t_digits    w_dig_b;
    logic       w_wr;

    // Config registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_bright <= 4'd5;
        end else if (w_wr) begin
            case (paddr[2])
                REG_MODE:   r_mode   <= pwdata[0];
                REG_BRIGHT: r_bright <= pwdata[3:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE:   prdata = {31'd0, r_mode};
            REG_BRIGHT: prdata = {28'd0, r_bright};
            default:    prdata = '0;
        endcase
    end

    // Value lanes
    ssvd_lane u_lane_a (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_value  (s_axis_tdata[17:0]),
        .o_digits (w_dig_a)
    );

    ssvd_lane u_lane_b (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_value  (s_axis_tdata[35:18]),
        .o_digits (w_dig_b)
    );

    // Merge and serialize
    ssvd_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_en       (w_en),
        .i_dig_a    (w_dig_a),
        .i_dig_b    (w_dig_b),
        .i_mode     (r_mode),
        .i_bright   (r_bright),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

    assign s_axis_tready = w_en;

endmodule

`default_nettype wire

FILE: rtl/core/ssvd_lane.sv
`default_nettype none

// One value lane: round hundredths to tenths, split into digits, encode segments.
// Three register stages, all advancing together on i_en.
module ssvd_lane
    import ssvd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic signed [17:0] i_value,
    output t_digits                o_digits
);

    // Stage 1: magnitude, round to tenths, raw range check
    logic [17:0] w_mag;
    logic [17:0] w_x;
    logic [35:0] w_prod;
    logic        w_rover;

    logic        r_neg1;
    logic        r_rover1;
    logic [13:0] r_ten1;

    always_comb begin
        w_mag  = i_value[17] ? (~i_value + 18'd1) : i_value;
        w_x    = w_mag + 18'd5;
        w_prod = w_x * RECIP10_S21;
        w_rover = i_value[17] ? (i_value <= NEG_RAW_LIMIT) : (i_value > POS_RAW_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1   <= i_value[17];
            r_rover1 <= w_rover;
            r_ten1   <= w_prod[34:21];
        end
    end

    // Stage 2: quotients by 10, 100, 1000 and range check
    logic [26:0] w_p10;
    logic [27:0] w_p100;
    logic [28:0] w_p1000;
    logic        w_over;

    logic        r_neg2;
    logic        r_over2;
    logic [13:0] r_ten2;
    logic [10:0] r_q1;
    logic [7:0]  r_q2;
    logic [3:0]  r_q3;

    always_comb begin
        w_p10   = r_ten1 * RECIP10_S16;
        w_p100  = r_ten1 * RECIP100_S20;
        w_p1000 = r_ten1 * RECIP1000_S24;
        w_over  = r_rover1 ||
                  (r_neg1 ? (r_ten1 >= NEG_TEN_LIMIT) : (r_ten1 >= POS_TEN_LIMIT));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2  <= r_neg1;
            r_over2 <= w_over;
            r_ten2  <= r_ten1;
            r_q1    <= w_p10[26:16];
            r_q2    <= w_p100[27:20];
            r_q3    <= w_p1000[27:24];
        end
    end

    // Stage 3: remainders give the digits, then segment patterns
    logic [13:0] w_r3;
    logic [10:0] w_r2;
    logic [7:0]  w_r1;
    t_digits     w_dig;
    t_digits     r_dig;

    always_comb begin
        w_r3 = r_ten2 - ({r_q1, 3'b000} + {2'b00, r_q1, 1'b0});
        w_r2 = r_q1 - ({r_q2, 3'b000} + {2'b00, r_q2, 1'b0});
        w_r1 = r_q2 - ({1'b0, r_q3, 3'b000} + {3'b000, r_q3, 1'b0});
        if (r_over2) begin
            w_dig[0] = SEG_OVER;
            w_dig[1] = r_neg2 ? SEG_MINUS : SEG_NINE;
            w_dig[2] = SEG_NINE;
            w_dig[3] = SEG_NINE;
        end else begin
            w_dig[0] = r_neg2 ? SEG_MINUS : seg_font(r_q3);
            w_dig[1] = seg_font(w_r1[3:0]);
            w_dig[2] = seg_font(w_r2[3:0]) | SEG_DOT;
            w_dig[3] = seg_font(w_r3[3:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dig <= w_dig;
        end
    end

    assign o_digits = r_dig;

endmodule

`default_nettype wire

FILE: rtl/core/ssvd_frame.sv
`default_nettype none

// Merges lane digits into the command byte sequence; sends a byte per cycle unless stalled.
module ssvd_frame
    import ssvd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_en,
    input  wire t_digits    i_dig_a,
    input  wire t_digits    i_dig_b,
    input  wire logic       i_mode,
    input  wire logic [3:0] i_bright,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic [1:0]      o_tuser,
    output logic            o_tlast
);

    logic [2:0] r_vld;
    logic       r_hvld;
    t_digits    r_hold_a;
    t_digits    r_hold_b;
    logic [3:0] r_idx;
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_ostart;
    logic       r_oend;
    logic       r_olast;

    logic       w_out_load;
    logic       w_release;
    logic       w_hold_load;
    logic [3:0] w_last_idx;
    logic [3:0] w_pos;
    logic [7:0] w_dig;
    logic [7:0] w_byte;
    logic       w_start;
    logic       w_end;
    logic       w_is_last;

    // Handshake between output register, digit holding register and lanes
    always_comb begin
        w_last_idx  = i_mode ? IDX_LAST_TWO : IDX_LAST_ONE;
        w_out_load  = r_hvld && (!r_ovld || i_tready);
        w_is_last   = (r_idx == w_last_idx);
        w_release   = w_out_load && w_is_last;
        w_hold_load = !r_hvld || w_release;
        o_en        = !r_vld[2] || w_hold_load;
    end

    // Byte selection for the current position
    always_comb begin
        w_pos = r_idx - IDX_DIG0;
        w_dig = w_pos[2] ? r_hold_b[w_pos[1:0]] : r_hold_a[w_pos[1:0]];
        if (r_idx == IDX_DATA) begin
            w_byte  = CMD_DATA;
            w_start = 1'b1;
            w_end   = 1'b1;
        end else if (r_idx == IDX_ADDR) begin
            w_byte  = CMD_ADDR;
            w_start = 1'b1;
            w_end   = 1'b0;
        end else if (w_is_last) begin
            w_byte  = i_mode ? bright_cmd(i_bright) : CMD_SINGLE_BRIGHT;
            w_start = 1'b1;
            w_end   = 1'b1;
        end else begin
            w_byte  = w_dig;
            w_start = 1'b0;
            w_end   = (r_idx == w_last_idx - 4'd1);
        end
    end

    // Lane valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (o_en) begin
            r_vld <= {r_vld[1:0], i_in_valid};
        end
    end

    // Digit holding register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= 1'b0;
            r_idx  <= IDX_DATA;
        end else begin
            if (r_vld[2] && w_hold_load) begin
                r_hvld <= 1'b1;
            end else if (w_release) begin
                r_hvld <= 1'b0;
            end
            if (w_out_load) begin
                r_idx <= w_is_last ? IDX_DATA : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[2] && w_hold_load) begin
            r_hold_a <= i_dig_a;
            r_hold_b <= i_dig_b;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (i_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_obyte  <= w_byte;
            r_ostart <= w_start;
            r_oend   <= w_end;
            r_olast  <= w_is_last;
        end
    end

    assign o_tvalid = r_ovld;
    assign o_tdata  = r_obyte;
    assign o_tuser  = {r_oend, r_ostart};
    assign o_tlast  = r_olast;

endmodule

`default_nettype wire

FILE: verif/tb_seven_segment_value_display_frame.sv
`timescale 1ns / 100ps

module tb_seven_segment_value_display_frame;
    import ssvd_pkg::*;

    localparam int N_DIR          = 19;
    localparam int N_PHASES       = 7;
    localparam int RAND_PER_PHASE = 50;
    localparam int TAIL_CYCLES    = 16;
    localparam int CYCLE_LIMIT    = 200000;

    // One driver byte as seen on the output stream
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       stop;
        logic       last;
    } t_drv_byte;

    // Directed row: two values, optionally with the digits typed in by hand
    typedef struct packed {
        logic signed [17:0] first;
        logic signed [17:0] second;
        logic               typed;
        t_digits            first_dig;
        t_digits            second_dig;
    } t_test_row;

    localparam t_digits SHOW_OVER_POS = {SEG_NINE, SEG_NINE, SEG_NINE, SEG_OVER};
    localparam t_digits SHOW_OVER_NEG = {SEG_NINE, SEG_NINE, SEG_MINUS, SEG_OVER};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [17:0] first_value, [35:18] second_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic [1:0]  m_axis_tuser;   // [0] frame_start, [1] frame_end
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Segment patterns for 0..9 and brightness commands for levels 0..8
    logic [7:0] digit_seg [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                    8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F};
    logic [7:0] dim_code [0:8]  = '{8'h80, 8'h88, 8'h89, 8'h8A, 8'h8B,
                                    8'h8C, 8'h8D, 8'h8E, 8'h8F};

    // Register settings and idling per phase
    int ph_mode [0:N_PHASES-1]   = '{1, 0, 1, 1, 1, 0, 1};
    int ph_bright [0:N_PHASES-1] = '{5, 0, 0, 8, 15, 9, 3};
    int ph_send [0:N_PHASES-1]   = '{0, 82, 0, 37, 0, 37, 82};
    int ph_recv [0:N_PHASES-1]   = '{0, 0, 82, 37, 0, 37, 82};

    // Local copy of the registers
    logic       cfg_two_value;
    logic [3:0] cfg_bright;

    t_drv_byte expected_bytes [$];
    t_test_row dir_rows [0:N_DIR-1];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int bytes_checked  = 0;
    int cycle_count    = 0;

    seven_segment_value_display_frame DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_digits digs(input logic [7:0] d0, d1, d2, d3);
        return {d3, d2, d1, d0};
    endfunction

    // Round hundredths half away from zero to tenths and map to four digits
    function automatic t_digits encode_digits(input logic signed [17:0] v);
        int      val;
        int      mag;
        int      tenths;
        logic    neg;
        t_digits d;
        val    = v;
        neg    = (val < 0);
        mag    = neg ? -val : val;
        tenths = (mag + 5) / 10;
        if (!neg && (val > 100000 || tenths >= 10000)) begin
            d = SHOW_OVER_POS;
        end else if (neg && (val <= -10000 || tenths >= 1000)) begin
            d = SHOW_OVER_NEG;
        end else begin
            d[0] = neg ? SEG_MINUS : digit_seg[(tenths / 1000) % 10];
            d[1] = digit_seg[(tenths / 100) % 10];
            d[2] = digit_seg[(tenths / 10) % 10] | SEG_DOT;
            d[3] = digit_seg[tenths % 10];
        end
        return d;
    endfunction

    // Whole byte sequence for one item under the current register settings
    task automatic queue_frame(input t_digits first_dig, input t_digits second_dig);
        int         ndig;
        logic [7:0] dig;
        logic [7:0] bright;
        ndig = cfg_two_value ? 8 : 4;
        expected_bytes.push_back('{CMD_DATA, 1'b1, 1'b1, 1'b0});
        expected_bytes.push_back('{CMD_ADDR, 1'b1, 1'b0, 1'b0});
        for (int i = 0; i < ndig; i++) begin
            dig = (i < 4) ? first_dig[i] : second_dig[i-4];
            expected_bytes.push_back('{dig, 1'b0, (i == ndig - 1), 1'b0});
        end
        if (cfg_two_value) begin
            bright = dim_code[(cfg_bright > 4'd8) ? 8 : cfg_bright];
        end else begin
            bright = CMD_SINGLE_BRIGHT;
        end
        expected_bytes.push_back('{bright, 1'b1, 1'b1, 1'b1});
    endtask

    // Mix of full-range noise, in-range values and rounding edges
    function automatic logic signed [17:0] gen_value();
        int pick;
        int edges [0:4];
        edges = '{100000, 99995, -10000, -9995, 0};
        case ($urandom_range(0, 9))
            0, 1:    pick = $signed($urandom() & 32'h3FFFF) - ($urandom() & 32'h20000) * 0;
            2, 3:    pick = $urandom_range(0, 100100);
            4, 5:    pick = -$signed($urandom_range(0, 10010));
            6:       pick = edges[$urandom_range(0, 4)] + $signed($urandom_range(0, 16)) - 8;
            7:       pick = $signed($urandom_range(0, 40)) - 20;
            default: pick = $signed($urandom_range(0, 110000)) - 10010;
        endcase
        return pick[17:0];
    endfunction

    task automatic send_item(input logic signed [17:0] a, input logic signed [17:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Setup and access phase, then the bus is left idle before the task returns
    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODE) begin
            cfg_two_value = val[0];
        end else begin
            cfg_bright = val[3:0];
        end
        @(posedge i_clk);
    endtask

    // Wait until every expected byte has come, then let the pipeline settle
    task automatic drain();
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output checker
    always @(posedge i_clk) begin
        t_drv_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte 0x%02h with nothing pending", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.start) begin
                    $error("frame_start: expected %0b, got %0b", want.start, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[1] !== want.stop) begin
                    $error("frame_end: expected %0b, got %0b", want.stop, m_axis_tuser[1]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic signed [17:0] a;
        logic signed [17:0] b;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        m_axis_tready <= 1'b1;
        cfg_two_value = 1'b1;
        cfg_bright    = 4'd5;

        // Range limits, rounding edges and small negatives; hand-typed digits
        // only where they are obvious
        dir_rows = '{
            '{18'sd0, 18'sd0, 1'b1,
              digs(8'h3F, 8'h3F, 8'hBF, 8'h3F), digs(8'h3F, 8'h3F, 8'hBF, 8'h3F)},
            '{18'sd131071, -18'sd131072, 1'b1, SHOW_OVER_POS, SHOW_OVER_NEG},
            '{18'sd100000, -18'sd10000, 1'b1, SHOW_OVER_POS, SHOW_OVER_NEG},
            '{18'sd100001, -18'sd9999, 1'b1, SHOW_OVER_POS, SHOW_OVER_NEG},
            '{18'sd99994, -18'sd9994, 1'b1,
              digs(8'h6F, 8'h6F, 8'hEF, 8'h6F), digs(8'h40, 8'h6F, 8'hEF, 8'h6F)},
            '{18'sd99995, -18'sd9995, 1'b1, SHOW_OVER_POS, SHOW_OVER_NEG},
            '{-18'sd4, 18'sd4, 1'b1,
              digs(8'h40, 8'h3F, 8'hBF, 8'h3F), digs(8'h3F, 8'h3F, 8'hBF, 8'h3F)},
            '{18'sd5, -18'sd5, 1'b1,
              digs(8'h3F, 8'h3F, 8'hBF, 8'h06), digs(8'h40, 8'h3F, 8'hBF, 8'h06)},
            '{-18'sd1, 18'sd1, 1'b1,
              digs(8'h40, 8'h3F, 8'hBF, 8'h3F), digs(8'h3F, 8'h3F, 8'hBF, 8'h3F)},
            '{18'sd12345, -18'sd1234, 1'b0, '0, '0},
            '{18'sd15, -18'sd15, 1'b0, '0, '0},
            '{18'sd1000, -18'sd1000, 1'b0, '0, '0},
            '{18'sd99949, 18'sd99950, 1'b0, '0, '0},
            '{-18'sd9949, -18'sd9950, 1'b0, '0, '0},
            '{18'sd54321, 18'sd6789, 1'b0, '0, '0},
            '{-18'sd2, 18'sd131000, 1'b0, '0, '0},
            '{18'sd65535, -18'sd65536, 1'b0, '0, '0},
            '{18'sd45, -18'sd45, 1'b0, '0, '0},
            '{18'sd99999, -18'sd131071, 1'b0, '0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at reset settings, no idling
        for (int n = 0; n < N_DIR; n++) begin
            send_item(dir_rows[n].first, dir_rows[n].second);
            if (dir_rows[n].typed) begin
                queue_frame(dir_rows[n].first_dig, dir_rows[n].second_dig);
            end else begin
                queue_frame(encode_digits(dir_rows[n].first),
                            encode_digits(dir_rows[n].second));
            end
        end

        // Random phases, each with its own register settings and idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                reg_write(REG_MODE, ph_mode[ph]);
                reg_write(REG_BRIGHT, ph_bright[ph]);
            end
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                a = gen_value();
                b = gen_value();
                send_item(a, b);
                queue_frame(encode_digits(a), encode_digits(b));
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        $display("%0d items over %0d register settings, %0d driver bytes checked",
                 items_sent, N_PHASES, bytes_checked);
        $display("single and dual mode, brightness off to saturated, gaps and stalls both sides");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
